// File: hdl/cbd_pkg.sv
// Package for the console CPU bus decoder: item types, target codes and
// the fixed addresses of the memory map. No dependencies.
package cbd_pkg;

    localparam int ADDR_W  = 16;
    localparam int BYTE_W  = 8;
    localparam int MIRR_W  = 11;
    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 32;
    localparam int M_USER_W = 4;

    localparam logic [ADDR_W-1:0] ADDR_AUDIO_LO = 16'h4000;
    localparam logic [ADDR_W-1:0] ADDR_AUDIO_HI = 16'h4013;
    localparam logic [ADDR_W-1:0] ADDR_DMA      = 16'h4014;
    localparam logic [ADDR_W-1:0] ADDR_STATUS   = 16'h4015;
    localparam logic [ADDR_W-1:0] ADDR_PAD1     = 16'h4016;
    localparam logic [ADDR_W-1:0] ADDR_PAD2     = 16'h4017;
    localparam logic [ADDR_W-1:0] ADDR_PIC_LO   = 16'h2000;
    localparam logic [ADDR_W-1:0] RAM_MIRR_MASK = 16'h07FF;
    localparam logic [ADDR_W-1:0] PIC_REG_MASK  = 16'h0007;

    typedef enum logic [2:0] {
        TGT_RAM   = 3'd0,
        TGT_PAD   = 3'd1,
        TGT_AUDIO = 3'd2,
        TGT_CART  = 3'd3,
        TGT_PIC   = 3'd4,
        TGT_DMA   = 3'd5
    } tgt_t;

    typedef logic [1:0][BYTE_W-1:0] pad_arr_t;

    typedef struct packed {
        logic              mode;
        logic [ADDR_W-1:0] bus_address;
        logic [BYTE_W-1:0] write_byte;
        logic [15:0]       pad_buttons;
        logic [BYTE_W-1:0] external_read_byte;
    } in_item_t;

    typedef struct packed {
        tgt_t              target;
        logic [ADDR_W-1:0] target_address;
        logic              target_write;
        logic [BYTE_W-1:0] target_data;
        logic [BYTE_W-1:0] read_byte;
    } out_item_t;

    typedef struct packed {
        logic [1:0] we;
        pad_arr_t   value;
    } pad_upd_t;

endpackage

// File: hdl/cbd_ram.sv
// Internal work RAM of the bus decoder, addressed by the 11-bit mirrored
// CPU address folded onto DEPTH entries. Depends on cbd_pkg.
module cbd_ram #(
    parameter int DEPTH = 2048
) (
    input  logic                       aclk,
    input  logic                       en,
    input  logic                       we,
    input  logic [cbd_pkg::MIRR_W-1:0] mirr_addr,
    input  logic [cbd_pkg::BYTE_W-1:0] wdata,
    output logic [cbd_pkg::BYTE_W-1:0] rdata
);
    import cbd_pkg::*;

    localparam int AW = $clog2(DEPTH);

    logic [BYTE_W-1:0]    mem [DEPTH];
    logic [MIRR_W-1:0]    folded;
    logic [AW+MIRR_W-1:0] folded_wide;
    logic [AW-1:0]        idx;
    logic [BYTE_W-1:0]    rdata_reg;

    // The mirrored address is below 2048; DEPTH must be at least 256 (the block
    // does not enforce it), so at most seven multiples fit under it; each is a compare.
    always_comb begin
        folded = mirr_addr;
        for (int k = 1; k < 8; k++) begin
            if (k * DEPTH < (1 << MIRR_W)) begin
                if (int'(mirr_addr) >= k * DEPTH) begin
                    folded = mirr_addr - MIRR_W'(k * DEPTH);
                end
            end
        end
    end

    assign folded_wide = {{AW{1'b0}}, folded};
    assign idx         = folded_wide[AW-1:0];

    always_ff @(posedge aclk) begin
        if (en && we) begin
            mem[idx] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rdata_reg <= mem[idx];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hdl/cbd_decode.sv
// Address decode of one bus access: picks the target, forms the result item
// and the controller register update. Depends on cbd_pkg.
module cbd_decode (
    input  cbd_pkg::in_item_t           item,
    input  logic [cbd_pkg::BYTE_W-1:0]  ram_rdata,
    input  cbd_pkg::pad_arr_t           pad_shift,
    output cbd_pkg::out_item_t          result,
    output cbd_pkg::pad_upd_t           pad_upd
);
    import cbd_pkg::*;

    logic              wr;
    logic [ADDR_W-1:0] addr;
    logic              audio_range;
    logic              pad_sel;
    logic [BYTE_W-1:0] rdata;

    assign wr      = item.mode;
    assign addr    = item.bus_address;
    assign pad_sel = addr[0];
    assign audio_range = (addr >= ADDR_AUDIO_LO && addr <= ADDR_AUDIO_HI)
                      || addr == ADDR_STATUS || addr == ADDR_PAD2;

    always_comb begin
        result.target         = TGT_RAM;
        result.target_address = addr;
        rdata                 = item.external_read_byte;
        pad_upd.we            = 2'b00;
        pad_upd.value         = pad_shift;
        priority if (!wr && (addr == ADDR_PAD1 || addr == ADDR_PAD2)) begin
            // Serial read: hand out bit 0, shift the rest down.
            result.target            = TGT_PAD;
            rdata                    = {{(BYTE_W-1){1'b0}}, pad_shift[pad_sel][0]};
            pad_upd.we[pad_sel]      = 1'b1;
            pad_upd.value[pad_sel]   = pad_shift[pad_sel] >> 1;
        end else if (wr && addr == ADDR_DMA) begin
            result.target = TGT_DMA;
        end else if (wr && addr == ADDR_PAD1) begin
            result.target = TGT_PAD;
            pad_upd.we    = 2'b11;
            pad_upd.value = item.pad_buttons;
        end else if (audio_range) begin
            result.target = TGT_AUDIO;
        end else if (addr >= ADDR_AUDIO_LO) begin
            result.target = TGT_CART;
        end else if (addr >= ADDR_PIC_LO) begin
            result.target         = TGT_PIC;
            result.target_address = addr & PIC_REG_MASK;
        end else begin
            result.target         = TGT_RAM;
            result.target_address = addr & RAM_MIRR_MASK;
            rdata                 = ram_rdata;
        end
        result.target_write = wr;
        result.target_data  = wr ? item.write_byte : '0;
        result.read_byte    = wr ? '0 : rdata;
    end

endmodule

// File: hdl/console_cpu_bus_decoder_core.sv
// Top level of the console CPU bus decoder: input stage, work RAM, controller
// shift registers and result register. Depends on cbd_pkg, cbd_ram, cbd_decode.
//
//  Channel | Direction | tdata (low bit up)                          | tuser
//  s_      | in        | bus_address, write_byte, pad_buttons,       | mode
//          |           | external_read_byte (48 bits)                |
//  m_      | out       | target_address, target_data, read_byte (32) | target, target_write
//
// Every access passes from acceptance through the input stage, where the RAM
// read returns, and then the result register. One access is accepted per
// clock while s_tready is high; the RAM port is written and read at the
// acceptance edge, so a read always sees the write of the access before it.
// A stall on m_tready holds the result register, then the input stage, and
// then drops s_tready; the input stage takes items while either slot is free.
// aresetn is synchronous and active low; it empties both stages and clears the
// controller shift registers. The RAM keeps no reset and needs no clearing.
module console_cpu_bus_decoder_core #(
    parameter int RAM_DEPTH = 2048
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // Input items.
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [cbd_pkg::S_DATA_W-1:0] s_tdata,  // bus_address, write_byte, pad_buttons,
                                                   // external_read_byte
    input  logic                         s_tuser,  // mode
    // Result items.
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [cbd_pkg::M_DATA_W-1:0] m_tdata,  // target_address, target_data, read_byte
    output logic [cbd_pkg::M_USER_W-1:0] m_tuser   // target, target_write
);
    import cbd_pkg::*;

    in_item_t          s_item;
    logic              s_accept;
    logic              s_is_ram;
    logic              a_move;
    logic              b_free;
    logic [BYTE_W-1:0] ram_rdata;
    out_item_t         dec_result;
    pad_upd_t          pad_upd;

    in_item_t  a_item_reg;
    logic      a_valid_reg;
    out_item_t b_item_reg;
    logic      b_valid_reg;
    pad_arr_t  pad_shift_reg;
    pad_arr_t  pad_shift_next;

    // Unpack the input item.
    assign s_item.mode               = s_tuser;
    assign s_item.bus_address        = s_tdata[15:0];
    assign s_item.write_byte         = s_tdata[23:16];
    assign s_item.pad_buttons        = s_tdata[39:24];
    assign s_item.external_read_byte = s_tdata[47:40];

    // Two-slot pipeline flow control.
    assign b_free   = !b_valid_reg || m_tready;
    assign a_move   = a_valid_reg && b_free;
    assign s_tready = !a_valid_reg || b_free;
    assign s_accept = s_tvalid && s_tready;

    // Only writes to addresses below the picture unit window reach the RAM.
    assign s_is_ram = (s_item.bus_address < ADDR_PIC_LO);

    cbd_ram #(
        .DEPTH(RAM_DEPTH)
    ) u_ram (
        .aclk      (aclk),
        .en        (s_accept),
        .we        (s_is_ram && s_item.mode),
        .mirr_addr (s_item.bus_address[MIRR_W-1:0]),
        .wdata     (s_item.write_byte),
        .rdata     (ram_rdata)
    );

    cbd_decode u_decode (
        .item      (a_item_reg),
        .ram_rdata (ram_rdata),
        .pad_shift (pad_shift_reg),
        .result    (dec_result),
        .pad_upd   (pad_upd)
    );

    // The controller registers change as their access leaves the input stage,
    // which keeps updates in access order.
    always_comb begin
        pad_shift_next = pad_shift_reg;
        if (a_move) begin
            for (int p = 0; p < 2; p++) begin
                if (pad_upd.we[p]) begin
                    pad_shift_next[p] = pad_upd.value[p];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            pad_shift_reg <= '0;
        end else begin
            pad_shift_reg <= pad_shift_next;
            if (s_tready) begin
                a_valid_reg <= s_tvalid;
            end
            if (b_free) begin
                b_valid_reg <= a_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            a_item_reg <= s_item;
        end
        if (a_move) begin
            b_item_reg <= dec_result;
        end
    end

    // Pack the result item.
    assign m_tvalid = b_valid_reg;
    assign m_tdata  = {b_item_reg.read_byte, b_item_reg.target_data,
                       b_item_reg.target_address};
    assign m_tuser  = {b_item_reg.target_write, b_item_reg.target};

    // An empty input stage must always take a new item.
    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !a_valid_reg |-> s_tready)
        else $error("input stage empty but not ready");

    // A controller latch write loads both pads from the buttons of that access.
    pad_latch: assert property (@(posedge aclk) disable iff (!aresetn)
        (a_move && a_item_reg.mode && a_item_reg.bus_address == ADDR_PAD1)
        |=> pad_shift_reg == $past(a_item_reg.pad_buttons))
        else $error("controller latch lost");

    // RAM results carry only the mirrored address bits.
    ram_mirror: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && b_item_reg.target == TGT_RAM)
        |-> b_item_reg.target_address[ADDR_W-1:MIRR_W] == '0)
        else $error("RAM address not mirrored");

    // Writes never return read data; reads never forward write data.
    rw_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (b_item_reg.target_write ? b_item_reg.read_byte == '0
                                              : b_item_reg.target_data == '0))
        else $error("read and write data mixed");

endmodule
